// ===== rtl/core/combined_twister_mwc_sbox_rng_assert.svh =====
// assertion macros used by the checker file
`ifndef COMBINED_TWISTER_MWC_SBOX_RNG_ASSERT_SVH
`define COMBINED_TWISTER_MWC_SBOX_RNG_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRNG_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CRNG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/crng_pkg.sv =====
package crng_pkg;

	// twister geometry
	localparam logic [9:0] TW_N    = 10'd624;
	localparam logic [9:0] TW_LAST = 10'd623;
	localparam logic [9:0] TW_M    = 10'd397;
	localparam logic [9:0] TW_WRAP = 10'd227;

	localparam logic [31:0] TW_A     = 32'h9908b0df;
	localparam logic [31:0] TW_UP    = 32'h80000000;
	localparam logic [31:0] TW_LO    = 32'h7fffffff;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;

	localparam int unsigned MWC_STREAMS = 16;

	// request codes
	localparam logic ACT_GENERATE = 1'b0;
	localparam logic ACT_LOAD     = 1'b1;

	// load targets
	localparam logic [2:0] TGT_TWISTER  = 3'd0;
	localparam logic [2:0] TGT_STAGGER  = 3'd1;
	localparam logic [2:0] TGT_MWC_ST   = 3'd2;
	localparam logic [2:0] TGT_MWC_MUL  = 3'd3;
	localparam logic [2:0] TGT_SBOX     = 3'd4;
	localparam logic [2:0] TGT_SBOX_PTR = 3'd5;
	localparam logic [2:0] TGT_TW_POS   = 3'd6;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LIM_DIV,
		ST_LIM_WAIT,
		ST_TW_CHK,
		ST_RG_INIT,
		ST_RG_LOAD,
		ST_RG_RD,
		ST_RG_WR,
		ST_TW_RD,
		ST_TW_TMP,
		ST_SG_RD,
		ST_SG_WR,
		ST_SB_P0,
		ST_SB_P1,
		ST_SB_P2,
		ST_SB_P3,
		ST_SB_T,
		ST_SB_W0,
		ST_SB_R1,
		ST_SB_W2,
		ST_SB_R3,
		ST_SB_W1,
		ST_SB_W3,
		ST_SB_RA,
		ST_SB_RB,
		ST_SB_RC,
		ST_SB_RD,
		ST_SB_RE,
		ST_SB_RF,
		ST_SB_RG,
		ST_Q_DIV,
		ST_Q_WAIT,
		ST_DONE
	} crng_state_t;

	// divider request
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	// one twister recurrence step
	function automatic logic [31:0] twist_mix(input logic [31:0] hi, input logic [31:0] lo,
		input logic [31:0] far);
		logic [31:0] y;
		y = (hi & TW_UP) | (lo & TW_LO);
		return far ^ (y >> 1) ^ (y[0] ? TW_A : 32'h0);
	endfunction

	// output tempering
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== rtl/core/combined_twister_mwc_sbox_rng.sv =====
// channel  | direction | handshake            | payload
// request  | in        | in_valid / in_ready  | action, load_target, load_index,
//          |           |                      | load_value, limit
// result   | out       | out_valid/ out_ready | random_value
//
// a load request gives no result
// a raw word is built by a chain of sbox memory reads and writes
// every 624th word first regenerates the twister state, each word in a read state and then a write state
// a nonzero limit adds a bound divide and one divide per draw (1-bit-per-cycle divider)
// stores need no clearing after reset; in_ready drops while a request is worked on
// a finished result waits in the output register while the next request is taken
module combined_twister_mwc_sbox_rng
	import crng_pkg::*;
#(
	parameter int STAGGER_DEPTH = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [2:0]  load_target,
	input  logic [15:0] load_index,
	input  logic [63:0] load_value,
	input  logic [31:0] limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_value
);

	localparam int SG_AW = $clog2(STAGGER_DEPTH);

	crng_state_t state_q;
	crng_state_t state_d;

	// captured request
	logic [2:0]  tgt_q;
	logic [15:0] idx_q;
	logic [63:0] val_q;
	logic [31:0] lim_q;

	// twister
	logic [31:0] tw_mem [624];
	logic [31:0] tw_rda_q;
	logic [31:0] tw_rdb_q;
	logic [9:0]  pos_q;
	logic [9:0]  k_q;
	logic [31:0] cur_q;
	logic [31:0] t_q;
	logic        tw_rea;
	logic        tw_reb;
	logic [9:0]  tw_ra;
	logic [9:0]  tw_rb;
	logic        tw_we;
	logic [9:0]  tw_wa;
	logic [31:0] tw_wd;

	// stagger table
	logic [31:0]      sg_mem [STAGGER_DEPTH];
	logic [31:0]      sg_rd_q;
	logic             sg_re;
	logic             sg_we;
	logic [SG_AW-1:0] sg_ra;
	logic [SG_AW-1:0] sg_wa;
	logic [31:0]      sg_wd;
	logic [31:0]      old_q;

	// mwc streams
	logic [63:0] mwc_st_q  [MWC_STREAMS];
	logic [31:0] mwc_mul_q [MWC_STREAMS];
	logic [3:0]  mwc_sel;
	logic [63:0] prod_q;
	logic [63:0] mwc_sum;

	// sbox
	logic [15:0] sb_mem [65536];
	logic [15:0] sb_rd_q;
	logic        sb_re;
	logic        sb_we;
	logic [15:0] sb_ra;
	logic [15:0] sb_wa;
	logic [15:0] sb_wd;
	logic [15:0] ptr_q [4];
	logic [15:0] sb_t_q;
	logic [15:0] sb_a_q;
	logic [15:0] sb_c_q;
	logic [15:0] lo_q;

	// draw and result
	logic [31:0] raw_q;
	logic [31:0] divq_q;
	logic [31:0] res_q;
	logic [7:0]  tries_q;
	logic        out_valid_q;
	logic [31:0] rv_q;
	logic        emit;

	// divider
	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_quo;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign random_value = rv_q;
	assign emit         = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign mwc_sel      = t_q[17:14];
	assign mwc_sum      = prod_q + {32'd0, mwc_st_q[mwc_sel][63:32]};

	crng_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_LOAD) state_d = ST_LOAD;
					else if (limit == 32'd0) state_d = ST_TW_CHK;
					else state_d = ST_LIM_DIV;
				end
			end
			ST_LOAD:     state_d = ST_IDLE;
			ST_LIM_DIV:  state_d = ST_LIM_WAIT;
			ST_LIM_WAIT: if (div_done) state_d = ST_TW_CHK;
			ST_TW_CHK:   state_d = (pos_q >= TW_N) ? ST_RG_INIT : ST_TW_RD;
			ST_RG_INIT:  state_d = ST_RG_LOAD;
			ST_RG_LOAD:  state_d = ST_RG_RD;
			ST_RG_RD:    state_d = ST_RG_WR;
			ST_RG_WR:    state_d = (k_q == TW_LAST) ? ST_TW_RD : ST_RG_RD;
			ST_TW_RD:    state_d = ST_TW_TMP;
			ST_TW_TMP:   state_d = ST_SG_RD;
			ST_SG_RD:    state_d = ST_SG_WR;
			ST_SG_WR:    state_d = ST_SB_P0;
			ST_SB_P0:    state_d = ST_SB_P1;
			ST_SB_P1:    state_d = ST_SB_P2;
			ST_SB_P2:    state_d = ST_SB_P3;
			ST_SB_P3:    state_d = ST_SB_T;
			ST_SB_T:     state_d = ST_SB_W0;
			ST_SB_W0:    state_d = ST_SB_R1;
			ST_SB_R1:    state_d = ST_SB_W2;
			ST_SB_W2:    state_d = ST_SB_R3;
			ST_SB_R3:    state_d = ST_SB_W1;
			ST_SB_W1:    state_d = ST_SB_W3;
			ST_SB_W3:    state_d = ST_SB_RA;
			ST_SB_RA:    state_d = ST_SB_RB;
			ST_SB_RB:    state_d = ST_SB_RC;
			ST_SB_RC:    state_d = ST_SB_RD;
			ST_SB_RD:    state_d = ST_SB_RE;
			ST_SB_RE:    state_d = ST_SB_RF;
			ST_SB_RF:    state_d = ST_SB_RG;
			ST_SB_RG:    state_d = (lim_q == 32'd0) ? ST_DONE : ST_Q_DIV;
			ST_Q_DIV:    state_d = ST_Q_WAIT;
			ST_Q_WAIT: begin
				if (div_done) begin
					if (div_quo < lim_q || tries_q == 8'd255) state_d = ST_DONE;
					else state_d = ST_TW_CHK;
				end
			end
			ST_DONE:     if (emit) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory strobes and divider requests
	always_comb begin
		tw_rea  = 1'b0;
		tw_reb  = 1'b0;
		tw_ra   = 10'd0;
		tw_rb   = 10'd0;
		tw_we   = 1'b0;
		tw_wa   = k_q;
		tw_wd   = twist_mix(cur_q, tw_rda_q, tw_rdb_q);
		sg_re   = 1'b0;
		sg_ra   = t_q[SG_AW-1:0];
		sg_we   = 1'b0;
		sg_wa   = t_q[SG_AW-1:0];
		sg_wd   = sg_rd_q ^ mwc_sum[31:0];
		sb_re   = 1'b0;
		sb_ra   = ptr_q[0];
		sb_we   = 1'b0;
		sb_wa   = ptr_q[0];
		sb_wd   = sb_rd_q;
		div_req = '{start: 1'b0, dividend: raw_q, divisor: divq_q};
		unique case (state_q)
			ST_LOAD: begin
				if (tgt_q == TGT_TWISTER && idx_q < 16'd624) begin
					tw_we = 1'b1;
					tw_wa = idx_q[9:0];
					tw_wd = val_q[31:0];
				end
				if (tgt_q == TGT_STAGGER && {16'd0, idx_q} < 32'(STAGGER_DEPTH)) begin
					sg_we = 1'b1;
					sg_wa = idx_q[SG_AW-1:0];
					sg_wd = val_q[31:0];
				end
				if (tgt_q == TGT_SBOX) begin
					sb_we = 1'b1;
					sb_wa = idx_q;
					sb_wd = val_q[15:0];
				end
			end
			ST_LIM_DIV: begin
				div_req = '{start: 1'b1, dividend: ALL_ONES, divisor: lim_q};
			end
			ST_Q_DIV: begin
				div_req.start = 1'b1;
			end
			ST_RG_INIT: begin
				tw_rea = 1'b1;
				tw_ra  = 10'd0;
			end
			ST_RG_RD: begin
				tw_rea = 1'b1;
				tw_ra  = (k_q == TW_LAST) ? 10'd0 : k_q + 10'd1;
				tw_reb = 1'b1;
				tw_rb  = (k_q >= TW_WRAP) ? k_q - TW_WRAP : k_q + TW_M;
			end
			ST_RG_WR: begin
				tw_we = 1'b1;
			end
			ST_TW_RD: begin
				tw_rea = 1'b1;
				tw_ra  = pos_q;
			end
			ST_SG_RD: sg_re = 1'b1;
			ST_SG_WR: sg_we = 1'b1;
			ST_SB_P0: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[0] + 16'd1;
			end
			ST_SB_P1: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[1] ^ sb_rd_q;
			end
			ST_SB_P2: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[2] ^ sb_rd_q;
			end
			ST_SB_P3: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[0];
			end
			ST_SB_T: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[2];
			end
			ST_SB_W0: begin
				sb_we = 1'b1;
				sb_wa = ptr_q[0];
			end
			ST_SB_R1: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[1];
			end
			ST_SB_W2: begin
				sb_we = 1'b1;
				sb_wa = ptr_q[2];
			end
			ST_SB_R3: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[3];
			end
			ST_SB_W1: begin
				sb_we = 1'b1;
				sb_wa = ptr_q[1];
			end
			ST_SB_W3: begin
				sb_we = 1'b1;
				sb_wa = ptr_q[3];
				sb_wd = sb_t_q;
			end
			ST_SB_RA: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[0];
			end
			ST_SB_RB: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[2];
			end
			ST_SB_RC: begin
				sb_re = 1'b1;
				sb_ra = sb_a_q ^ sb_rd_q;
			end
			ST_SB_RD: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[1];
			end
			ST_SB_RE: begin
				sb_re = 1'b1;
				sb_ra = ptr_q[3];
			end
			ST_SB_RF: begin
				sb_re = 1'b1;
				sb_ra = sb_c_q ^ sb_rd_q;
			end
			default: begin
			end
		endcase
	end

	// twister memory, two read ports
	always_ff @(posedge clk) begin
		if (tw_we) tw_mem[tw_wa] <= tw_wd;
		if (tw_rea) tw_rda_q <= tw_mem[tw_ra];
		if (tw_reb) tw_rdb_q <= tw_mem[tw_rb];
	end

	// stagger memory
	always_ff @(posedge clk) begin
		if (sg_we) sg_mem[sg_wa] <= sg_wd;
		if (sg_re) sg_rd_q <= sg_mem[sg_ra];
	end

	// sbox memory
	always_ff @(posedge clk) begin
		if (sb_we) sb_mem[sb_wa] <= sb_wd;
		if (sb_re) sb_rd_q <= sb_mem[sb_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= 10'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD && tgt_q == TGT_TW_POS) pos_q <= val_q[9:0];
			if (state_q == ST_RG_WR && k_q == TW_LAST) pos_q <= 10'd0;
			if (state_q == ST_TW_TMP) pos_q <= pos_q + 10'd1;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					tgt_q   <= load_target;
					idx_q   <= load_index;
					val_q   <= load_value;
					lim_q   <= limit;
					tries_q <= 8'd0;
				end
			end
			ST_LOAD: begin
				if (tgt_q == TGT_MWC_ST && idx_q < 16'd16) mwc_st_q[idx_q[3:0]] <= val_q;
				if (tgt_q == TGT_MWC_MUL && idx_q < 16'd16) begin
					mwc_mul_q[idx_q[3:0]] <= val_q[31:0];
				end
				if (tgt_q == TGT_SBOX_PTR && idx_q < 16'd4) ptr_q[idx_q[1:0]] <= val_q[15:0];
			end
			ST_LIM_WAIT: if (div_done) divq_q <= div_quo;
			ST_RG_LOAD: begin
				cur_q <= tw_rda_q;
				k_q   <= 10'd0;
			end
			ST_RG_WR: begin
				cur_q <= tw_rda_q;
				k_q   <= k_q + 10'd1;
			end
			ST_TW_TMP: t_q <= temper(tw_rda_q);
			ST_SG_RD: prod_q <= 64'(mwc_mul_q[mwc_sel]) * 64'(mwc_st_q[mwc_sel][31:0]);
			ST_SG_WR: begin
				old_q             <= sg_rd_q;
				mwc_st_q[mwc_sel] <= mwc_sum;
			end
			ST_SB_P0: ptr_q[0] <= ptr_q[0] + 16'd1;
			ST_SB_P1: ptr_q[1] <= ptr_q[1] ^ sb_rd_q;
			ST_SB_P2: ptr_q[2] <= ptr_q[2] ^ sb_rd_q;
			ST_SB_P3: ptr_q[3] <= ptr_q[3] ^ sb_rd_q;
			ST_SB_T:  sb_t_q <= sb_rd_q;
			ST_SB_RB: sb_a_q <= sb_rd_q;
			ST_SB_RD: lo_q <= sb_rd_q;
			ST_SB_RE: sb_c_q <= sb_rd_q;
			ST_SB_RG: begin
				raw_q <= old_q + {sb_rd_q, lo_q};
				res_q <= old_q + {sb_rd_q, lo_q};
			end
			ST_Q_WAIT: begin
				if (div_done) begin
					if (div_quo < lim_q) res_q <= div_quo;
					else if (tries_q == 8'd255) res_q <= lim_q - 32'd1;
					else tries_q <= tries_q + 8'd1;
				end
			end
			ST_DONE: if (emit) rv_q <= res_q;
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/crng_div.sv =====
module crng_div
	import crng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	// restoring step, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, dvs_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 32'd0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ~trial[32]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/crng_chk.sv =====
`include "combined_twister_mwc_sbox_rng_assert.svh"

module crng_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] random_value
);

	// a stalled result stays put
	`CRNG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(random_value), "result changed while stalled")

	// every accepted request drops ready in the following cycle
	`CRNG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a request")

	// a load request never produces a result
	`CRNG_ASSERT_NEXT(a_load_silent, in_valid && in_ready && action, !$rose(out_valid), "load request produced a result")

	// a result only appears after the block was busy
	`CRNG_ASSERT_IMPLY(a_result_after_work, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

bind combined_twister_mwc_sbox_rng crng_chk u_crng_chk (.*);
